>>> sv/crc16_packet_deframer_unit_defines.svh
// ----------------------------------------------------------------------------
// crc16_packet_deframer_unit_defines
// Assertion macros used by the deframer state machine.
// ----------------------------------------------------------------------------
`ifndef CRC16_PACKET_DEFRAMER_UNIT_DEFINES_SVH
`define CRC16_PACKET_DEFRAMER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CRC16PD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");
`define CRC16PD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");
`else
`define CRC16PD_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define CRC16PD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/crc16pd_pkg.sv
// ----------------------------------------------------------------------------
// crc16pd_pkg
// Types, constants and the CRC-16 byte update for the packet deframer.
// ----------------------------------------------------------------------------
package crc16pd_pkg;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_TYPE,
        PH_LENGTH,
        PH_CRC_LO,
        PH_CRC_HI,
        PH_PAYLOAD
    } t_phase;

    typedef enum logic {
        CFG_START_BYTE  = 1'b0,
        CFG_MAX_PAYLOAD = 1'b1
    } t_cfg_idx;

    localparam logic [7:0]  START_BYTE_RESET  = 8'hA1;
    localparam logic [7:0]  MAX_PAYLOAD_RESET = 8'd200;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
        logic [7:0] packet_type;
        logic [7:0] packet_length;
        logic       has_data;
        logic       packet_end;
        logic       crc_good;
    } t_result;

    // Reflected polynomial 0x8408, one byte per call.
    function automatic logic [15:0] crc_update(input logic [7:0] b, input logic [15:0] crc);
        logic [7:0] x;
        x = b ^ crc[7:0];
        x = x ^ {x[3:0], 4'b0000};
        return {x, crc[15:8]} ^ {12'b0, x[7:4]} ^ {5'b0, x, 3'b000};
    endfunction

endpackage

>>> sv/crc16pd_if.sv
// ----------------------------------------------------------------------------
// crc16pd_if
// Valid/ready channels for received bytes and deframed result items.
// ----------------------------------------------------------------------------
interface crc16pd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface crc16pd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
    logic [7:0] packet_type;
    logic [7:0] packet_length;
    logic       has_data;
    logic       packet_end;
    logic       crc_good;

    modport source (
        output valid, output payload_byte, output byte_index, output packet_type,
        output packet_length, output has_data, output packet_end, output crc_good,
        input ready
    );
    modport sink (
        input valid, input payload_byte, input byte_index, input packet_type,
        input packet_length, input has_data, input packet_end, input crc_good,
        output ready
    );
endinterface

>>> sv/crc16_packet_deframer_unit.sv
// ----------------------------------------------------------------------------
// crc16_packet_deframer_unit
// A result item is registered; it appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle; input is taken while the output register is
// empty or being drained in the same cycle.
// Reset is synchronous and active low: hunting, CRC at 0xFFFF, registers at defaults.
// ----------------------------------------------------------------------------
module crc16_packet_deframer_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  crc16pd_pkg::t_cfg_idx  i_cfg_idx,
    input  logic [7:0]             i_cfg_data,
    crc16pd_in_if.sink             i_rx,
    crc16pd_out_if.source          o_res
);
    import crc16pd_pkg::*;

    logic [7:0] r_start_byte;
    logic [7:0] r_max_payload;
    logic       r_out_valid;
    t_result    r_out;

    logic       w_in_ready;
    logic       w_accept;
    logic       w_emit;
    t_result    w_result;

    assign w_in_ready = !r_out_valid || o_res.ready;
    assign w_accept   = i_rx.valid && w_in_ready;
    assign i_rx.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte  <= START_BYTE_RESET;
            r_max_payload <= MAX_PAYLOAD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_BYTE:  r_start_byte  <= i_cfg_data;
                CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data;
                default: begin
                    r_start_byte <= r_start_byte;
                end
            endcase
        end
    end

    crc16pd_fsm u_fsm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_accept),
        .i_byte        (i_rx.rx_byte),
        .i_start_byte  (r_start_byte),
        .i_max_payload (r_max_payload),
        .o_emit        (w_emit),
        .o_result      (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= w_emit;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.payload_byte  = r_out.payload_byte;
    assign o_res.byte_index    = r_out.byte_index;
    assign o_res.packet_type   = r_out.packet_type;
    assign o_res.packet_length = r_out.packet_length;
    assign o_res.has_data      = r_out.has_data;
    assign o_res.packet_end    = r_out.packet_end;
    assign o_res.crc_good      = r_out.crc_good;

endmodule

>>> sv/crc16pd_fsm.sv
// ----------------------------------------------------------------------------
// crc16pd_fsm
// Framing state machine and running CRC; one byte is stepped per accepted item.
// ----------------------------------------------------------------------------
`include "crc16_packet_deframer_unit_defines.svh"

module crc16pd_fsm (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [7:0]            i_byte,
    input  logic [7:0]            i_start_byte,
    input  logic [7:0]            i_max_payload,
    output logic                  o_emit,
    output crc16pd_pkg::t_result  o_result
);
    import crc16pd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_length, n_length;
    logic [15:0] r_rx_crc, n_rx_crc;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_count, n_count;

    logic [15:0] w_crc_step;
    logic        w_last;

    assign w_crc_step = crc_update(i_byte, (r_phase == PH_TYPE) ? CRC_INIT : r_crc);
    assign w_last     = ({1'b0, r_count} + 9'd1) >= {1'b0, r_length};

    always_comb begin
        n_phase  = r_phase;
        n_type   = r_type;
        n_length = r_length;
        n_rx_crc = r_rx_crc;
        n_crc    = r_crc;
        n_count  = r_count;
        if (i_valid) begin
            case (r_phase)
                PH_TYPE: begin
                    n_type  = i_byte;
                    n_crc   = w_crc_step;
                    n_phase = PH_LENGTH;
                end
                PH_LENGTH: begin
                    if (i_byte > i_max_payload) begin
                        n_phase = PH_HUNT;
                    end else begin
                        n_length = i_byte;
                        n_crc    = w_crc_step;
                        n_phase  = PH_CRC_LO;
                    end
                end
                PH_CRC_LO: begin
                    n_rx_crc = {8'h00, i_byte};
                    n_phase  = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    n_rx_crc = {i_byte, r_rx_crc[7:0]};
                    n_count  = 8'd0;
                    n_phase  = (r_length == 8'd0) ? PH_HUNT : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    n_crc   = w_crc_step;
                    n_count = r_count + 8'd1;
                    if (w_last) begin
                        n_phase = PH_HUNT;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                    if (i_byte == i_start_byte) begin
                        n_crc   = CRC_INIT;
                        n_phase = PH_TYPE;
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_emit                 = 1'b0;
        o_result.payload_byte  = 8'd0;
        o_result.byte_index    = 8'd0;
        o_result.packet_type   = r_type;
        o_result.packet_length = r_length;
        o_result.has_data      = 1'b0;
        o_result.packet_end    = 1'b0;
        o_result.crc_good      = 1'b0;
        case (r_phase)
            PH_CRC_HI: begin
                if (r_length == 8'd0) begin
                    o_emit              = i_valid;
                    o_result.packet_end = 1'b1;
                    o_result.crc_good   = (r_crc == {i_byte, r_rx_crc[7:0]});
                end
            end
            PH_PAYLOAD: begin
                o_emit                = i_valid;
                o_result.payload_byte = i_byte;
                o_result.byte_index   = r_count;
                o_result.has_data     = 1'b1;
                o_result.packet_end   = w_last;
                o_result.crc_good     = w_last && (w_crc_step == r_rx_crc);
            end
            default: begin
                o_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_type   <= 8'd0;
            r_length <= 8'd0;
            r_rx_crc <= 16'd0;
            r_crc    <= CRC_INIT;
            r_count  <= 8'd0;
        end else begin
            r_phase  <= n_phase;
            r_type   <= n_type;
            r_length <= n_length;
            r_rx_crc <= n_rx_crc;
            r_crc    <= n_crc;
            r_count  <= n_count;
        end
    end

    `CRC16PD_ASSERT_SAME(a_payload_emits, i_clk, i_rst_n, i_valid && (r_phase == PH_PAYLOAD), o_emit && o_result.has_data)
    `CRC16PD_ASSERT_SAME(a_count_below_length, i_clk, i_rst_n, r_phase == PH_PAYLOAD, r_count < r_length)
    `CRC16PD_ASSERT_NEXT(a_oversize_hunts, i_clk, i_rst_n, i_valid && (r_phase == PH_LENGTH) && (i_byte > i_max_payload), r_phase == PH_HUNT)
    `CRC16PD_ASSERT_SAME(a_empty_result_ends, i_clk, i_rst_n, o_emit && !o_result.has_data, o_result.packet_end)

endmodule

>>> dv/crc16_packet_deframer_unit_checker.sv
// ----------------------------------------------------------------------------
// crc16_packet_deframer_unit_checker
// Watches the byte and result channels of the packet deframer, predicts every
// result item from its own model of the framing and the CRC-16, and compares
// each accepted result item, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module crc16_packet_deframer_unit_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  crc16pd_pkg::t_cfg_idx i_cfg_idx,
    input  logic [7:0]            i_cfg_data,
    crc16pd_in_if                 i_rx,
    crc16pd_out_if                i_res,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_good_ends,
    output int                    o_bad_ends
);
    timeunit 1ns;
    timeprecision 1ps;

    import crc16pd_pkg::*;

    localparam int PRINT_LIMIT = 30;

    logic [7:0]  start_value;
    logic [7:0]  length_limit;
    t_phase      rx_phase;
    logic [7:0]  pkt_type;
    logic [7:0]  pkt_len;
    logic [15:0] sent_crc;
    logic [15:0] calc_crc;
    logic [7:0]  data_count;
    t_result     pending_results[$];
    int          fails;
    int          checked;
    int          good_ends;
    int          bad_ends;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
        end
        return c;
    endfunction

    function automatic void clear_deframer();
        start_value  = START_BYTE_RESET;
        length_limit = MAX_PAYLOAD_RESET;
        rx_phase     = PH_HUNT;
        pkt_type     = 8'h00;
        pkt_len      = 8'h00;
        sent_crc     = 16'h0000;
        calc_crc     = CRC_INIT;
        data_count   = 8'h00;
    endfunction

    function automatic void deframe_byte(input logic [7:0] b, output logic emit,
                                         output t_result r);
        logic [7:0] idx;
        logic       last;
        emit = 1'b0;
        r    = '0;
        case (rx_phase)
            PH_TYPE: begin
                pkt_type = b;
                calc_crc = crc16_byte(CRC_INIT, b);
                rx_phase = PH_LENGTH;
            end
            PH_LENGTH: begin
                if (b > length_limit) begin
                    rx_phase = PH_HUNT;
                end else begin
                    pkt_len  = b;
                    calc_crc = crc16_byte(calc_crc, b);
                    rx_phase = PH_CRC_LO;
                end
            end
            PH_CRC_LO: begin
                sent_crc = {8'h00, b};
                rx_phase = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                sent_crc[15:8] = b;
                data_count     = 8'h00;
                if (pkt_len == 8'h00) begin
                    rx_phase = PH_HUNT;
                    emit     = 1'b1;
                    r = '{payload_byte: 8'h00, byte_index: 8'h00, packet_type: pkt_type,
                          packet_length: pkt_len, has_data: 1'b0, packet_end: 1'b1,
                          crc_good: calc_crc == sent_crc};
                end else begin
                    rx_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                idx        = data_count;
                last       = ({1'b0, idx} + 9'd1) >= {1'b0, pkt_len};
                calc_crc   = crc16_byte(calc_crc, b);
                data_count = idx + 8'd1;
                emit       = 1'b1;
                if (last) begin
                    rx_phase = PH_HUNT;
                end
                r = '{payload_byte: b, byte_index: idx, packet_type: pkt_type,
                      packet_length: pkt_len, has_data: 1'b1, packet_end: last,
                      crc_good: last && (calc_crc == sent_crc)};
            end
            default: begin
                rx_phase = PH_HUNT;
                if (b == start_value) begin
                    calc_crc = CRC_INIT;
                    rx_phase = PH_TYPE;
                end
            end
        endcase
    endfunction

    task automatic report(input string msg);
        fails++;
        if (fails <= PRINT_LIMIT) begin
            $display("%0t mismatch: %s", $realtime, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want) begin
            report($sformatf("result item %0d, %s is %0h, expected %0h", checked, name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        logic    emit;
        t_result made;
        t_result want;
        if (!i_rst_n) begin
            clear_deframer();
            pending_results.delete();
        end else begin
            if (i_rx.valid && i_rx.ready) begin
                deframe_byte(i_rx.rx_byte, emit, made);
                if (emit) begin
                    pending_results.push_back(made);
                end
            end
            if (i_res.valid && i_res.ready) begin
                if (pending_results.size() == 0) begin
                    report("result item arrived with nothing predicted");
                end else begin
                    want = pending_results.pop_front();
                    check_field("payload_byte", i_res.payload_byte, want.payload_byte);
                    check_field("byte_index", i_res.byte_index, want.byte_index);
                    check_field("packet_type", i_res.packet_type, want.packet_type);
                    check_field("packet_length", i_res.packet_length, want.packet_length);
                    check_field("has_data", 8'(i_res.has_data), 8'(want.has_data));
                    check_field("packet_end", 8'(i_res.packet_end), 8'(want.packet_end));
                    check_field("crc_good", 8'(i_res.crc_good), 8'(want.crc_good));
                    if (want.packet_end && want.crc_good) begin
                        good_ends++;
                    end else if (want.packet_end) begin
                        bad_ends++;
                    end
                end
                checked++;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_START_BYTE:  start_value  = i_cfg_data;
                    CFG_MAX_PAYLOAD: length_limit = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending    <= pending_results.size();
        o_fail_count <= fails;
        o_checked    <= checked;
        o_good_ends  <= good_ends;
        o_bad_ends   <= bad_ends;
    end

endmodule

>>> dv/crc16_packet_deframer_unit_test.sv
// ----------------------------------------------------------------------------
// crc16_packet_deframer_unit_test
// Drives framed and corrupted byte streams into the packet deframer under
// several register settings and flow-control patterns; a separate checker
// predicts and compares the result items, and this module gives the verdict.
// ----------------------------------------------------------------------------
module crc16_packet_deframer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import crc16pd_pkg::*;

    localparam int BYTES_PER_SETTING = 160;
    localparam int STALL_LIMIT       = 1000;
    localparam int SETTINGS_COUNT    = 8;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       cfg_we;
    t_cfg_idx   cfg_idx;
    logic [7:0] cfg_data;

    crc16pd_in_if  rx_ch();
    crc16pd_out_if res_ch();

    int         send_idle_pct;
    int         stall_pct;
    int         fail_count;
    int         pending;
    int         checked;
    int         good_ends;
    int         bad_ends;
    int         frame_bytes;
    int         noise_bytes;
    int         quiet_cycles;
    logic [7:0] cur_start;
    logic [7:0] cur_max;
    logic [7:0] start_tab [SETTINGS_COUNT] =
        '{8'hA1, 8'h00, 8'hFF, 8'h00, 8'hA1, 8'h5A, 8'hFF, 8'h00};
    logic [7:0] max_tab [SETTINGS_COUNT] =
        '{8'd200, 8'd255, 8'd0, 8'd8, 8'd200, 8'd3, 8'd255, 8'd12};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    crc16_packet_deframer_unit DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_rx      (rx_ch),
        .o_res     (res_ch)
    );

    crc16_packet_deframer_unit_checker u_scoreboard (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_rx        (rx_ch),
        .i_res       (res_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_good_ends (good_ends),
        .o_bad_ends  (bad_ends)
    );

    always @(posedge i_clk) begin
        res_ch.ready <= i_rst_n && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timed out after %0d cycles without any item moving.", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [15:0] frame_crc(input logic [7:0] ptype, input logic [7:0] len,
                                              input logic [7:0] body[$]);
        logic [7:0]  covered[$];
        logic [15:0] crc;
        covered = {ptype, len, body};
        crc     = CRC_INIT;
        foreach (covered[n]) begin
            crc = crc ^ {8'h00, covered[n]};
            repeat (8) begin
                crc = crc[0] ? ((crc >> 1) ^ 16'h8408) : (crc >> 1);
            end
        end
        return crc;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            rx_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do begin
            @(posedge i_clk);
        end while (!rx_ch.ready);
    endtask

    task automatic send_frame(input logic [7:0] ptype, input logic [7:0] len,
                              input logic [7:0] body[$], input bit corrupt);
        logic [15:0] crc;
        crc = frame_crc(ptype, len, body);
        if (corrupt) begin
            crc = crc ^ (16'h0001 << $urandom_range(15));
        end
        send_byte(cur_start);
        send_byte(ptype);
        send_byte(len);
        send_byte(crc[7:0]);
        send_byte(crc[15:8]);
        foreach (body[k]) begin
            send_byte(body[k]);
        end
        frame_bytes += 5 + body.size();
    endtask

    task automatic random_frame();
        logic [7:0] body[$];
        logic [7:0] ptype;
        int         len;
        int         kind;
        kind  = $urandom_range(99);
        ptype = 8'($urandom);
        if ($urandom_range(9) == 0) begin
            len = $urandom_range(int'(cur_max));
        end else begin
            len = $urandom_range(cur_max < 8'd12 ? int'(cur_max) : 12);
        end
        repeat (len) begin
            body.push_back(8'($urandom));
        end
        if (kind < 5 && cur_max != 8'hFF) begin
            body.delete();
            send_frame(ptype, 8'($urandom_range(255, int'(cur_max) + 1)), body, 1'b0);
        end else if (kind < 10 && len > 0) begin
            body.delete(len - 1);
            send_frame(ptype, 8'(len), body, 1'b0);
        end else begin
            send_frame(ptype, 8'(len), body, kind < 22);
        end
        repeat ($urandom_range(3)) begin
            send_byte(8'($urandom));
            noise_bytes++;
        end
    endtask

    task automatic quiesce();
        rx_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    task automatic configure(input logic [7:0] start_value, input logic [7:0] limit);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_START_BYTE;
        cfg_data <= start_value;
        @(posedge i_clk);
        cfg_idx  <= CFG_MAX_PAYLOAD;
        cfg_data <= limit;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        cur_start  = start_value;
        cur_max    = limit;
    endtask

    initial begin
        logic [7:0] body[$];
        int         target;
        bit         drained;
        bit         long_done;
        i_rst_n       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_idx       <= CFG_START_BYTE;
        cfg_data      <= 8'h00;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'h00;
        send_idle_pct  = 0;
        stall_pct      = 0;
        cur_start      = START_BYTE_RESET;
        cur_max        = MAX_PAYLOAD_RESET;
        long_done      = 1'b0;
        start_tab[3]   = 8'($urandom);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_byte(8'h00);
        send_byte(8'hFF);
        body.delete();
        send_frame(8'hFF, 8'd0, body, 1'b0);
        body = {8'hFF};
        send_frame(8'h00, 8'd1, body, 1'b0);
        body = {START_BYTE_RESET, 8'h00, START_BYTE_RESET};
        send_frame(8'h5A, 8'd3, body, 1'b1);
        body.delete();
        send_frame(8'h33, MAX_PAYLOAD_RESET + 8'd1, body, 1'b0);

        for (int p = 0; p < SETTINGS_COUNT; p++) begin
            quiesce();
            configure(start_tab[p], max_tab[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 70; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 70; end
                default: begin send_idle_pct = 10; stall_pct = 10; end
            endcase
            target  = frame_bytes + BYTES_PER_SETTING;
            drained = 1'b0;
            if (cur_max == 8'hFF && !long_done) begin
                body.delete();
                repeat (255) body.push_back(8'($urandom));
                send_frame(8'($urandom), 8'hFF, body, 1'b0);
                long_done = 1'b1;
            end
            while (frame_bytes < target) begin
                random_frame();
                if (!drained && frame_bytes >= target - BYTES_PER_SETTING / 2) begin
                    quiesce();
                    drained = 1'b1;
                end
            end
        end
        quiesce();

        $display("Sent %0d framed and %0d stray bytes across %0d register settings and four",
                 frame_bytes, noise_bytes, SETTINGS_COUNT + 1);
        $display("flow-control patterns; %0d result items checked, %0d good and %0d bad ends.",
                 checked, good_ends, bad_ends);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
